@@ hw/rtl/bq_pkg.sv @@
// ---------------------------------------------------------------------------
// bq_pkg: shared types and microcode for the cascadable biquad filter
// Control word layout, register indexes and the sequencer program ROM.
// ---------------------------------------------------------------------------
`default_nettype none

package bq_pkg;

	// Coefficient fraction bits (Q3.21)
	localparam int unsigned COEF_FRAC = 21;
	localparam int unsigned NUM_COEF  = 5;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned STEP_W    = 4;
	localparam logic [63:0] COEF_ONE  = 64'd1 << COEF_FRAC;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_CASCADE
	} cfg_reg_t;

	// Coefficient select; values match the storage slot of each coefficient
	typedef enum logic [2:0] {
		CS_B0,
		CS_B1,
		CS_B2,
		CS_A1,
		CS_A2
	} coef_sel_t;

	// History operand select
	typedef enum logic [1:0] {
		HS_W1,
		HS_W2,
		HS_W0
	} hist_sel_t;

	// Accumulator operation; LOAD_P, SUB and ADD take the product of the previous step
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_LOAD_P,
		ACC_SUB,
		ACC_ADD
	} acc_op_t;

	// Step counter control
	typedef enum logic {
		J_NEXT,
		J_END
	} jump_t;

	typedef struct packed {
		coef_sel_t coef_sel;
		hist_sel_t hist_sel;
		acc_op_t   acc_op;
		logic      w0_wr;
		jump_t     jump;
	} ucode_t;

	// Sequencer to datapath control bundle
	typedef struct packed {
		ucode_t word;
		logic   start;   // sample transfer, load x and clear clip
		logic   run;     // execute word this cycle
		logic   section; // 0 first section, 1 second section
		logic   cont;    // section end continues into second section
	} ctl_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// Program for one section:
	//   w0 = x - a1*w1 - a2*w2 (saturated), y = b0*w0 + b1*w1 + b2*w2
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		w = '{coef_sel: CS_B0, hist_sel: HS_W1, acc_op: ACC_HOLD,
			w0_wr: 1'b0, jump: J_NEXT};
		case (step)
			4'd0: begin
				w.coef_sel = CS_A1;
				w.hist_sel = HS_W1;
				w.acc_op   = ACC_LOAD_X;
			end
			4'd1: begin
				w.coef_sel = CS_A2;
				w.hist_sel = HS_W2;
				w.acc_op   = ACC_SUB;
			end
			4'd2: begin
				w.acc_op = ACC_SUB;
			end
			4'd3: begin
				w.w0_wr = 1'b1;
			end
			4'd4: begin
				w.coef_sel = CS_B0;
				w.hist_sel = HS_W0;
			end
			4'd5: begin
				w.coef_sel = CS_B1;
				w.hist_sel = HS_W1;
				w.acc_op   = ACC_LOAD_P;
			end
			4'd6: begin
				w.coef_sel = CS_B2;
				w.hist_sel = HS_W2;
				w.acc_op   = ACC_ADD;
			end
			4'd7: begin
				w.acc_op = ACC_ADD;
			end
			4'd8: begin
				w.jump = J_END;
			end
			default: begin
				w.jump = J_NEXT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bq_seq.sv @@
// ---------------------------------------------------------------------------
// bq_seq: microcode sequencer
// Step counter over the program ROM, section tracking and input handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module bq_seq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        cascade,
	input  wire logic        out_free,
	output bq_pkg::ctl_t     ctl,
	output logic             out_load
);
	import bq_pkg::*;

	seq_state_t        state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              section_q;
	ucode_t            word;
	logic              start, cont, stall, run;

	// Control word fetch and stall at the final section end while the output is full
	always_comb begin
		word  = ucode_rom(step_q);
		start = (state_q == SEQ_IDLE) && in_valid;
		cont  = !section_q && cascade;
		stall = (word.jump == J_END) && !cont && !out_free;
		run   = (state_q == SEQ_RUN) && !stall;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_valid) state_nxt = SEQ_RUN;
			end
			SEQ_RUN: begin
				if (run && (word.jump == J_END) && !cont) state_nxt = SEQ_IDLE;
			end
			default: state_nxt = SEQ_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = (state_q == SEQ_IDLE);
		ctl.word    = word;
		ctl.start   = start;
		ctl.run     = run;
		ctl.section = section_q;
		ctl.cont    = cont;
		out_load    = run && (word.jump == J_END) && !cont;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SEQ_IDLE;
			step_q    <= '0;
			section_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				step_q    <= '0;
				section_q <= 1'b0;
			end else if (run) begin
				if (word.jump == J_END) begin
					step_q    <= '0;
					section_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bq_dp.sv @@
// ---------------------------------------------------------------------------
// bq_dp: biquad datapath
// Shared multiplier, accumulator, saturation and both sections' history.
// ---------------------------------------------------------------------------
`default_nettype none

module bq_dp #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int COEF_WIDTH    = 24,
	parameter int HISTORY_WIDTH = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire bq_pkg::ctl_t                    ctl,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  sample_in,
	input  wire logic signed [COEF_WIDTH-1:0]    coef [bq_pkg::NUM_COEF],
	output logic signed [SAMPLE_WIDTH-1:0]       y_sat,
	output logic                                 clip_out
);
	import bq_pkg::*;

	localparam int PROD_W  = COEF_WIDTH + HISTORY_WIDTH;
	localparam int TERM_W  = PROD_W - COEF_FRAC;
	localparam int BASE_W  = (TERM_W > HISTORY_WIDTH) ? TERM_W : HISTORY_WIDTH;
	localparam int ACC_W   = ((BASE_W > SAMPLE_WIDTH) ? BASE_W : SAMPLE_WIDTH) + 2;
	localparam int H       = HISTORY_WIDTH;
	localparam int S       = SAMPLE_WIDTH;

	logic signed [S-1:0]      x_q;
	logic signed [TERM_W-1:0] term_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [H-1:0]      w0_q;
	logic signed [H-1:0]      h1_w1_q, h1_w2_q, h2_w1_q, h2_w2_q;
	logic                     clip_q;

	logic signed [H-1:0]      w1, w2, hist_op;
	logic signed [COEF_WIDTH-1:0] coef_op;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  term_ext, x_ext;
	logic signed [H-1:0]      w0_sat;
	logic                     w0_clip, y_clip;
	logic                     acc_sign;

	// Operand select
	always_comb begin
		w1 = ctl.section ? h2_w1_q : h1_w1_q;
		w2 = ctl.section ? h2_w2_q : h1_w2_q;
		case (ctl.word.hist_sel)
			HS_W1:   hist_op = w1;
			HS_W2:   hist_op = w2;
			HS_W0:   hist_op = w0_q;
			default: hist_op = w1;
		endcase
		coef_op = coef[ctl.word.coef_sel];
	end

	// Multiply and floor shift by the coefficient fraction
	assign prod = coef_op * hist_op;

	always_ff @(posedge clk) begin
		if (ctl.run) term_q <= prod[PROD_W-1:COEF_FRAC];
	end

	assign term_ext = {{(ACC_W-TERM_W){term_q[TERM_W-1]}}, term_q};
	assign x_ext    = {{(ACC_W-S){x_q[S-1]}}, x_q};

	// Accumulator
	always_ff @(posedge clk) begin
		if (ctl.run) begin
			case (ctl.word.acc_op)
				ACC_LOAD_X: acc_q <= x_ext;
				ACC_LOAD_P: acc_q <= term_ext;
				ACC_SUB:    acc_q <= acc_q - term_ext;
				ACC_ADD:    acc_q <= acc_q + term_ext;
				default:    acc_q <= acc_q;
			endcase
		end
	end

	// Saturation to history and sample widths
	always_comb begin
		acc_sign = acc_q[ACC_W-1];
		w0_clip  = (acc_q[ACC_W-1:H-1] != {(ACC_W-H+1){acc_sign}});
		w0_sat   = w0_clip ? {acc_sign, {(H-1){!acc_sign}}} : acc_q[H-1:0];
		y_clip   = (acc_q[ACC_W-1:S-1] != {(ACC_W-S+1){acc_sign}});
		y_sat    = y_clip ? {acc_sign, {(S-1){!acc_sign}}} : acc_q[S-1:0];
		clip_out = clip_q | y_clip;
	end

	// Section input and w0
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= sample_in;
		end else if (ctl.run && (ctl.word.jump == J_END) && ctl.cont) begin
			x_q <= y_sat;
		end
		if (ctl.run && ctl.word.w0_wr) w0_q <= w0_sat;
	end

	// Clip flag and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q  <= 1'b0;
			h1_w1_q <= '0;
			h1_w2_q <= '0;
			h2_w1_q <= '0;
			h2_w2_q <= '0;
		end else begin
			if (ctl.start) begin
				clip_q <= 1'b0;
			end else if (ctl.run && ctl.word.w0_wr) begin
				clip_q <= clip_q | w0_clip;
			end else if (ctl.run && (ctl.word.jump == J_END)) begin
				clip_q <= clip_out;
			end
			if (ctl.run && (ctl.word.jump == J_END)) begin
				if (ctl.section) begin
					h2_w2_q <= h2_w1_q;
					h2_w1_q <= w0_q;
				end else begin
					h1_w2_q <= h1_w1_q;
					h1_w1_q <= w0_q;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/biquad_iir_filter_cascadable_top.sv @@
// ---------------------------------------------------------------------------
// biquad_iir_filter_cascadable_top: cascadable direct form II biquad
// Microcoded single-multiplier filter with optional second section.
// ---------------------------------------------------------------------------
//  channel | signals                               | transfer when
//  --------+---------------------------------------+--------------------------
//  in      | in_valid, in_ready, sample_in         | in_valid & in_ready
//  out     | out_valid, out_ready, sample_out,     | out_valid & out_ready
//          | clipped                               |
//  cfg     | cfg_valid, cfg_ready, cfg_index,      | cfg_valid & cfg_ready
//          | cfg_data                              |
//
//  After the input transfer a sample runs nine program steps per section,
//  one section or two with cascade on, through the shared multiplier and
//  accumulator. in_ready is high whenever no sample is in flight, also
//  while a result sits in the output register. A full output register
//  stalls the sequencer on its last step. Reset clears the history, loads
//  default coefficients (b0 = 1.0, cascade off); no sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_cascadable_top #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int COEF_WIDTH    = 24,
	parameter int HISTORY_WIDTH = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [SAMPLE_WIDTH-1:0]      sample_in,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]           sample_out,
	output logic                                     clipped,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [COEF_WIDTH-1:0]               cfg_data
);
	import bq_pkg::*;

	logic signed [COEF_WIDTH-1:0] coef_q [NUM_COEF];
	logic                         cascade_q;
	logic                         out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                         clipped_q;
	ctl_t                         ctl;
	logic                         out_load, out_free;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                         clip_out;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[CS_B0] <= COEF_WIDTH'(COEF_ONE);
			coef_q[CS_B1] <= '0;
			coef_q[CS_B2] <= '0;
			coef_q[CS_A1] <= '0;
			coef_q[CS_A2] <= '0;
			cascade_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_B0:      coef_q[CS_B0] <= cfg_data;
				REG_B1:      coef_q[CS_B1] <= cfg_data;
				REG_B2:      coef_q[CS_B2] <= cfg_data;
				REG_A1:      coef_q[CS_A1] <= cfg_data;
				REG_A2:      coef_q[CS_A2] <= cfg_data;
				REG_CASCADE: cascade_q     <= cfg_data[0];
				default:     cascade_q     <= cascade_q;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	bq_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cascade  (cascade_q),
		.out_free (out_free),
		.ctl      (ctl),
		.out_load (out_load)
	);

	bq_dp #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.COEF_WIDTH    (COEF_WIDTH),
		.HISTORY_WIDTH (HISTORY_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample_in (sample_in),
		.coef      (coef_q),
		.y_sat     (y_sat),
		.clip_out  (clip_out)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q <= y_sat;
			clipped_q    <= clip_out;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

endmodule

`default_nettype wire

@@ dv/biquad_iir_filter_cascadable_top_tb.sv @@
// ---------------------------------------------------------------------------
// biquad_iir_filter_cascadable_top_tb: self-checking bench for the biquad
// Streams samples and coefficient writes over the valid/ready channels with
// random gaps, output back-pressure and long output stalls. A scoreboard
// keeps its own copy of the coefficients and both section histories, predicts
// every filtered sample and its clip flag, and checks results in order.
// ---------------------------------------------------------------------------

module biquad_iir_filter_cascadable_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bq_pkg::*;

	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 24;
	localparam int HIST_W       = 24;
	localparam int RESET_CYCLES = 7;
	localparam int NUM_PHASES   = 10;
	localparam int PHASE_ITEMS  = 200;
	localparam int CHOKE_CYCLES = 500;
	localparam int TAIL_CYCLES  = 40;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int Q21_ONE      = 1 << COEF_FRAC;

	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	// Indexes past the last register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] level;
		logic                       clip;
	} filt_out_t;

	// Filter predictor and in-order result checker
	class biquad_scoreboard;
		logic signed [COEF_W-1:0] coef [NUM_COEF];
		logic                     cascade_on;
		logic signed [HIST_W-1:0] hist [2][2];  // [section][w1, w2]
		filt_out_t                expected_q [$];
		bit                       clip_seen;
		int                       fails;

		function new();
			foreach (coef[i]) coef[i] = '0;
			coef[REG_B0] = COEF_W'(Q21_ONE);
			cascade_on = 1'b0;
			foreach (hist[s, k]) hist[s][k] = '0;
			fails = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Exact product, arithmetic shift floors toward minus infinity
		function longint mul_q21(longint c, longint h);
			return (c * h) >>> COEF_FRAC;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) << (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				clip_seen = 1'b1;
				return hi;
			end
			if (v < lo) begin
				clip_seen = 1'b1;
				return lo;
			end
			return v;
		endfunction

		function longint run_section(int s, longint x);
			longint w0;
			longint w1;
			longint w2;
			longint y;
			w1 = hist[s][0];
			w2 = hist[s][1];
			w0 = clamp(x - mul_q21(coef[REG_A1], w1) - mul_q21(coef[REG_A2], w2), HIST_W);
			y  = clamp(mul_q21(coef[REG_B0], w0) + mul_q21(coef[REG_B1], w1)
				+ mul_q21(coef[REG_B2], w2), SAMPLE_W);
			hist[s][1] = HIST_W'(w1);
			hist[s][0] = HIST_W'(w0);
			return y;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
			case (idx) inside
				REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: coef[idx] = data;
				REG_CASCADE: cascade_on = data[0];
				default: ;
			endcase
		endfunction

		// Input transfer: advance the histories and queue the expected output
		function void note_sample(logic signed [SAMPLE_W-1:0] x);
			longint    y;
			filt_out_t e;
			clip_seen = 1'b0;
			y = run_section(0, x);
			if (cascade_on)
				y = run_section(1, y);
			e.level = y[SAMPLE_W-1:0];
			e.clip  = clip_seen;
			expected_q.push_back(e);
		endfunction

		task report(string msg);
			fails++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic signed [SAMPLE_W-1:0] level, logic clip);
			filt_out_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d clip %b with no sample pending", level, clip));
				return;
			end
			e = expected_q.pop_front();
			if (level !== e.level)
				report($sformatf("sample_out %0d, expected %0d", level, e.level));
			if (clip !== e.clip)
				report($sformatf("clipped %b, expected %b (sample_out %0d)",
					clip, e.clip, e.level));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic signed [SAMPLE_W-1:0]  sample_in;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        clipped;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [COEF_W-1:0]           cfg_data;

	biquad_scoreboard sb = new();
	bit               choke_req;
	int unsigned      cycle_count;
	logic signed [SAMPLE_W-1:0] last_sample;

	biquad_iir_filter_cascadable_top #(
		.SAMPLE_WIDTH  (SAMPLE_W),
		.COEF_WIDTH    (COEF_W),
		.HISTORY_WIDTH (HIST_W)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.clipped    (clipped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** biquad_iir_filter_cascadable_top: FAILED **");
			$finish;
		end
	end

	// Transfer monitor: results are checked before the same-edge input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (out_valid && out_ready)
				sb.check_result(sample_out, clipped);
			if (in_valid && in_ready)
				sb.note_sample(sample_in);
		end
	end

	// Output back-pressure: random runs, plus one long stall on request
	initial begin
		int r;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (choke_req) begin
				choke_req = 1'b0;
				out_ready <= 1'b0;
				repeat (CHOKE_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_ready <= 1'b1;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end else if (r < 80) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(1, 2)) @(posedge clk);
				end else if (r < 93) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(3, 8)) @(posedge clk);
				end else if (r < 97) begin
					out_ready <= 1'b0;
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end else begin
					out_ready <= 1'b1;
					repeat ($urandom_range(100, 200)) @(posedge clk);
				end
			end
		end
	end

	// Offer one sample, hold it until transfer, then idle for the requested gap
	task automatic push_sample(input logic signed [SAMPLE_W-1:0] x, input int gap);
		in_valid  <= 1'b1;
		sample_in <= x;
		last_sample = x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Leaves cfg_valid high; the caller drops it after the burst
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_setup(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2,
			input logic cascade, input bit junk);
		logic [COEF_W-1:0] casc_word;
		casc_word    = COEF_W'($urandom());
		casc_word[0] = cascade;
		put_reg(REG_B0, b0);
		put_reg(REG_B1, b1);
		if (junk)
			put_reg(IDX_SPARE_LO, COEF_W'($urandom()));
		put_reg(REG_B2, b2);
		put_reg(REG_A1, a1);
		put_reg(REG_A2, a2);
		put_reg(REG_CASCADE, casc_word);
		if (junk)
			put_reg(IDX_SPARE_HI, COEF_W'($urandom()));
		cfg_valid <= 1'b0;
	endtask

	// Block is idle once every queued result has been transferred
	task automatic wait_idle();
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic int pick_gap(bit busy);
		int r;
		if (busy)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return SAMPLE_W'($urandom());
		if (r < 78)
			return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
		if (r < 90) begin
			case ($urandom_range(0, 3))
				0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
				1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
				2: return '0;
				default: return '1;
			endcase
		end
		// repeat the previous value: steps and DC drive the feedback hard
		return last_sample;
	endfunction

	function automatic logic signed [COEF_W-1:0] extreme_coef();
		case ($urandom_range(0, 5))
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return '0;
			3: return COEF_W'(Q21_ONE);
			4: return COEF_W'(-Q21_ONE);
			default: return COEF_W'($urandom());
		endcase
	endfunction

	// Stimulus
	initial begin
		logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
		int  ia2;
		int  lim;
		bit  busy;
		bit  cascade;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sample_in   = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		choke_req   = 1'b0;
		cycle_count = 0;
		last_sample = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults pass the sample straight through
		push_sample(16'sh7FFF, 0);
		push_sample(16'sh8000, 1);
		push_sample(16'sh0000, 0);
		push_sample(-16'sd1, 2);
		push_sample(16'sd1, 0);
		push_sample(16'sd12345, 0);
		in_valid <= 1'b0;

		// Coefficient extremes with cascade on: saturation everywhere,
		// plus writes to unused indexes
		wait_idle();
		apply_setup(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b1, 1'b1);
		push_sample(16'sh7FFF, 0);
		push_sample(16'sh8000, 0);
		push_sample(16'sh7FFF, 1);
		push_sample(16'sd1, 0);
		push_sample(-16'sd1, 0);
		in_valid <= 1'b0;

		// Cascade off: second section history must stay untouched
		wait_idle();
		apply_setup(COEF_W'(Q21_ONE / 2), COEF_W'(Q21_ONE / 4), COEF_W'(Q21_ONE / 8),
			COEF_W'(-Q21_ONE / 2), COEF_W'(Q21_ONE / 4), 1'b0, 1'b0);
		push_sample(16'sd20000, 0);
		push_sample(-16'sd20000, 0);
		push_sample(16'sd7, 0);
		in_valid <= 1'b0;

		// Cascade back on: second section resumes from its old history
		wait_idle();
		apply_setup(COEF_W'(Q21_ONE / 2), COEF_W'(Q21_ONE / 4), COEF_W'(Q21_ONE / 8),
			COEF_W'(-Q21_ONE / 2), COEF_W'(Q21_ONE / 4), 1'b1, 1'b0);
		push_sample(16'sd100, 0);
		push_sample(-16'sd100, 3);
		push_sample(16'sd0, 0);
		push_sample(16'sd30000, 0);
		in_valid <= 1'b0;

		// All-zero coefficients
		wait_idle();
		apply_setup('0, '0, '0, '0, '0, 1'b0, 1'b0);
		push_sample(16'sh8000, 0);
		push_sample(16'sh7FFF, 0);
		in_valid <= 1'b0;

		// Random phases: stable designs, raw random words, extreme mixes
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p % 3)
				0: begin
					ia2 = int'($urandom_range(0, 2 * Q21_ONE - 2)) - (Q21_ONE - 1);
					lim = Q21_ONE + ia2 - 1;
					a2  = COEF_W'(ia2);
					a1  = COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
					b0  = COEF_W'(int'($urandom_range(0, Q21_ONE)) - Q21_ONE / 2);
					b1  = COEF_W'(int'($urandom_range(0, Q21_ONE)) - Q21_ONE / 2);
					b2  = COEF_W'(int'($urandom_range(0, Q21_ONE)) - Q21_ONE / 2);
				end
				1: begin
					b0 = COEF_W'($urandom());
					b1 = COEF_W'($urandom());
					b2 = COEF_W'($urandom());
					a1 = COEF_W'($urandom());
					a2 = COEF_W'($urandom());
				end
				default: begin
					b0 = extreme_coef();
					b1 = extreme_coef();
					b2 = extreme_coef();
					a1 = extreme_coef();
					a2 = extreme_coef();
				end
			endcase
			cascade = p[0] ^ (p > 5);
			apply_setup(b0, b1, b2, a1, a2, cascade, bit'($urandom_range(0, 1)));

			// back-to-back phases; two of them also get the long output stall
			busy = (p == 2 || p == 4 || p == 7);
			if (p == 2 || p == 7)
				choke_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_sample(pick_sample(), pick_gap(busy));
			in_valid <= 1'b0;
		end

		// Drain and let any stray output show up
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.fails == 0)
			$display("** biquad_iir_filter_cascadable_top: PASSED **");
		else
			$display("** biquad_iir_filter_cascadable_top: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bq_pkg.sv
hw/rtl/bq_seq.sv
hw/rtl/bq_dp.sv
hw/rtl/biquad_iir_filter_cascadable_top.sv
dv/biquad_iir_filter_cascadable_top_tb.sv
